### rtl/core/assert_macros.svh
// Assertion macros shared by the attitude mixer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed in attitude mixer");

`endif

### rtl/core/qpam_pkg.sv
// Package with types, constants and helper functions of the attitude mixer.
`timescale 1ns / 1ps

package qpam_pkg;

    // Fixed-point formats: angles signed Q10.6, gains unsigned Q8.8.
    localparam int ANGLE_FRAC_BITS = 6;
    localparam int GAIN_FRAC_BITS  = 8;
    localparam int FRAC_BITS       = ANGLE_FRAC_BITS + GAIN_FRAC_BITS;

    localparam int ANGLE_W = 16;
    localparam int GAIN_W  = 16;
    localparam int MOTOR_W = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;

    // Error and angle-change width; leaves room for targets of up to 10 << 6.
    localparam int ERR_W  = ANGLE_W + 2;
    localparam int PROD_W = GAIN_W + 1 + ERR_W;
    localparam int AXIS_W = PROD_W + 1;
    localparam int THR_W  = MOTOR_W + FRAC_BITS + 1;
    localparam int SUM_W  = ((AXIS_W > THR_W) ? AXIS_W : THR_W) + 2;

    localparam logic signed [ERR_W-1:0] TGT_TEN   = ERR_W'(10 << ANGLE_FRAC_BITS);
    localparam logic signed [ERR_W-1:0] TGT_THREE = ERR_W'(3 << ANGLE_FRAC_BITS);

    // Remote command characters.
    localparam logic [7:0] CMD_FORWARD  = 8'h31;
    localparam logic [7:0] CMD_BACKWARD = 8'h34;
    localparam logic [7:0] CMD_LEFT     = 8'h37;
    localparam logic [7:0] CMD_RIGHT    = 8'h39;
    localparam logic [7:0] CMD_START    = 8'h38;
    localparam logic [7:0] CMD_CLIMB    = 8'h36;
    localparam logic [7:0] CMD_DESCEND  = 8'h32;
    localparam logic [7:0] CMD_YAW_NEG  = 8'h33;
    localparam logic [7:0] CMD_YAW_POS  = 8'h35;

    localparam logic [MOTOR_W-1:0] THR_START = 16'd400;
    localparam logic [MOTOR_W-1:0] THR_UP    = 16'd50;
    localparam logic [MOTOR_W-1:0] THR_DOWN  = 16'd100;

    localparam logic [1:0] YAW_ZERO = 2'd0;
    localparam logic [1:0] YAW_NEG  = 2'd1;
    localparam logic [1:0] YAW_POS  = 2'd2;

    localparam logic REQ_CMD  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROLL_KP   = 3'd0,
        REG_ROLL_KD   = 3'd1,
        REG_PITCH_KP  = 3'd2,
        REG_PITCH_KD  = 3'd3,
        REG_YAW_KP    = 3'd4,
        REG_YAW_KD    = 3'd5,
        REG_MOTOR_MAX = 3'd6,
        REG_START_THR = 3'd7
    } t_cfg_reg;

    typedef struct packed {
        logic                      req_type;
        logic [7:0]                cmd_byte;
        logic signed [ANGLE_W-1:0] roll_meas;
        logic signed [ANGLE_W-1:0] pitch_meas;
        logic signed [ANGLE_W-1:0] yaw_meas;
    } t_mix_in;

    typedef struct packed {
        logic [MOTOR_W-1:0] motor_one;
        logic [MOTOR_W-1:0] motor_two;
        logic [MOTOR_W-1:0] motor_three;
        logic [MOTOR_W-1:0] motor_four;
        logic               fault_toggle;
    } t_mix_out;

    // Floor the fixed-point sum to an integer and clamp it to 0..max.
    function automatic logic [MOTOR_W-1:0] to_motor(input logic signed [SUM_W-1:0] sum,
                                                    input logic [MOTOR_W-1:0] max_val);
        logic signed [SUM_W-1:0] v;
        logic [SUM_W-1:0]        lim;
        logic [MOTOR_W-1:0]      res;
        v   = sum >>> FRAC_BITS;
        lim = {{(SUM_W-MOTOR_W){1'b0}}, max_val};
        if (sum < 0) begin
            res = '0;
        end else if ($unsigned(v) > lim) begin
            res = max_val;
        end else begin
            res = v[MOTOR_W-1:0];
        end
        return res;
    endfunction

endpackage

### rtl/core/quadrotor_pd_attitude_mixer.sv
// Top level of the quadrotor PD attitude controller with X-form motor mixer.
// Each transaction passes through the input register, then the result register, and waits in the
// input register while the result register is full and not taken. Throughput: one transaction
// per cycle while the output is taken; the PD terms, mix and clamp run in one combinational pass.
// Reset (i_rst_n low, synchronous): both pipeline registers empty, gains and limits at their
// defaults, flags, throttle, previous angles, held motors and the fault level cleared.
`timescale 1ns / 1ps
// Configuration writes take effect at the next clock edge and should be made while idle.
`include "assert_macros.svh"

module quadrotor_pd_attitude_mixer (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  qpam_pkg::t_mix_in                       i_in_data,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output qpam_pkg::t_mix_out                      o_out_data,
    input  logic                                    i_cfg_we,
    input  logic [qpam_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [qpam_pkg::CFG_W-1:0]              i_cfg_data
);
    import qpam_pkg::*;

    // Configuration registers.
    logic [GAIN_W-1:0]  r_roll_kp, r_roll_kd, r_pitch_kp, r_pitch_kd, r_yaw_kp, r_yaw_kd;
    logic [MOTOR_W-1:0] r_motor_max, r_start_thr;

    // Input register stage.
    logic    r_in_valid;
    t_mix_in r_in;

    // Result register; its motor fields and fault bit are also the held state.
    logic     r_out_valid;
    t_mix_out r_out;
    t_mix_out n_out;

    // Controller state.
    logic                      r_fwd, r_bwd, r_left, r_right;
    logic                      n_fwd, n_bwd, n_left, n_right;
    logic [1:0]                r_yaw_code, n_yaw_code;
    logic [MOTOR_W-1:0]        r_thr, n_thr;
    logic signed [ANGLE_W-1:0] r_prev_roll, r_prev_pitch, r_prev_yaw;

    // The item in the input register moves on whenever the result register is free or
    // is being emptied in the same cycle, so the stages never stall each other needlessly.
    logic w_adv;
    assign w_adv       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_adv;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    logic w_tick;
    assign w_tick = (r_in.req_type == REQ_TICK);

    // Targets follow the direction flags; left and forward win over their opposites.
    logic signed [ERR_W-1:0] w_roll_tgt, w_pitch_tgt, w_yaw_tgt;
    assign w_roll_tgt  = r_left ? -TGT_TEN : (r_right ? TGT_TEN : '0);
    assign w_pitch_tgt = r_fwd  ? -TGT_TEN : (r_bwd   ? TGT_TEN : '0);
    assign w_yaw_tgt   = (r_yaw_code == YAW_NEG) ? -TGT_THREE :
                         ((r_yaw_code == YAW_POS) ? TGT_THREE : '0);

    // Proportional acts on measured minus target, derivative on measured minus previous.
    logic signed [ERR_W-1:0] w_roll_err, w_pitch_err, w_yaw_err;
    logic signed [ERR_W-1:0] w_roll_dlt, w_pitch_dlt, w_yaw_dlt;
    assign w_roll_err  = ERR_W'(r_in.roll_meas)  - w_roll_tgt;
    assign w_pitch_err = ERR_W'(r_in.pitch_meas) - w_pitch_tgt;
    assign w_yaw_err   = ERR_W'(r_in.yaw_meas)   - w_yaw_tgt;
    assign w_roll_dlt  = ERR_W'(r_in.roll_meas)  - ERR_W'(r_prev_roll);
    assign w_pitch_dlt = ERR_W'(r_in.pitch_meas) - ERR_W'(r_prev_pitch);
    assign w_yaw_dlt   = ERR_W'(r_in.yaw_meas)   - ERR_W'(r_prev_yaw);

    // Six independent gain multiplies, unsigned gains widened by a zero sign bit.
    logic signed [PROD_W-1:0] w_roll_p, w_roll_d, w_pitch_p, w_pitch_d, w_yaw_p, w_yaw_d;
    assign w_roll_p  = $signed({1'b0, r_roll_kp})  * w_roll_err;
    assign w_roll_d  = $signed({1'b0, r_roll_kd})  * w_roll_dlt;
    assign w_pitch_p = $signed({1'b0, r_pitch_kp}) * w_pitch_err;
    assign w_pitch_d = $signed({1'b0, r_pitch_kd}) * w_pitch_dlt;
    assign w_yaw_p   = $signed({1'b0, r_yaw_kp})   * w_yaw_err;
    assign w_yaw_d   = $signed({1'b0, r_yaw_kd})   * w_yaw_dlt;

    logic signed [AXIS_W-1:0] w_ro, w_po, w_yo;
    assign w_ro = AXIS_W'(w_roll_p)  + AXIS_W'(w_roll_d);
    assign w_po = AXIS_W'(w_pitch_p) + AXIS_W'(w_pitch_d);
    assign w_yo = AXIS_W'(w_yaw_p)   + AXIS_W'(w_yaw_d);

    // X-form mix, all in Q(A+G); the throttle is scaled up to the same format.
    logic signed [SUM_W-1:0] w_t, w_ro_s, w_po_s, w_yo_s;
    logic signed [SUM_W-1:0] w_m1, w_m2, w_m3, w_m4;
    assign w_t    = $signed({{(SUM_W-MOTOR_W){1'b0}}, r_thr}) <<< FRAC_BITS;
    assign w_ro_s = SUM_W'(w_ro);
    assign w_po_s = SUM_W'(w_po);
    assign w_yo_s = SUM_W'(w_yo);
    assign w_m1   = w_t + w_ro_s + w_po_s + w_yo_s;
    assign w_m2   = w_t - w_ro_s - w_po_s + w_yo_s;
    assign w_m3   = w_t + w_ro_s - w_po_s - w_yo_s;
    assign w_m4   = w_t - w_ro_s + w_po_s - w_yo_s;

    logic w_unknown;

    // Next state and result for the item in the input register.
    always_comb begin
        n_fwd      = r_fwd;
        n_bwd      = r_bwd;
        n_left     = r_left;
        n_right    = r_right;
        n_yaw_code = r_yaw_code;
        n_thr      = r_thr;
        n_out      = r_out;
        w_unknown  = 1'b0;
        if (w_tick) begin
            if (r_thr > r_start_thr) begin
                n_out.motor_one   = to_motor(w_m1, r_motor_max);
                n_out.motor_two   = to_motor(w_m2, r_motor_max);
                n_out.motor_three = to_motor(w_m3, r_motor_max);
                n_out.motor_four  = to_motor(w_m4, r_motor_max);
            end else begin
                n_out.motor_one   = '0;
                n_out.motor_two   = '0;
                n_out.motor_three = '0;
                n_out.motor_four  = '0;
            end
        end else begin
            case (r_in.cmd_byte)
                CMD_FORWARD: begin
                    n_fwd = 1'b1;
                    n_bwd = 1'b0;
                end
                CMD_BACKWARD: begin
                    n_bwd = 1'b1;
                    n_fwd = 1'b0;
                end
                CMD_LEFT: begin
                    n_left  = 1'b1;
                    n_right = 1'b0;
                end
                CMD_RIGHT: begin
                    n_right = 1'b1;
                    n_left  = 1'b0;
                end
                CMD_START: begin
                    n_thr = THR_START;
                end
                CMD_CLIMB: begin
                    // Saturate at full scale.
                    if (r_thr > ~THR_UP) begin
                        n_thr = '1;
                    end else begin
                        n_thr = r_thr + THR_UP;
                    end
                end
                CMD_DESCEND: begin
                    if (r_thr < THR_DOWN) begin
                        n_thr = '0;
                    end else begin
                        n_thr = r_thr - THR_DOWN;
                    end
                end
                CMD_YAW_NEG: begin
                    n_yaw_code = YAW_NEG;
                end
                CMD_YAW_POS: begin
                    n_yaw_code = YAW_POS;
                end
                default: begin
                    w_unknown          = 1'b1;
                    n_out.fault_toggle = ~r_out.fault_toggle;
                end
            endcase
        end
    end

    // Configuration port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_roll_kp   <= 16'd614;
            r_roll_kd   <= 16'd25600;
            r_pitch_kp  <= 16'd614;
            r_pitch_kd  <= 16'd25600;
            r_yaw_kp    <= 16'd512;
            r_yaw_kd    <= 16'd2560;
            r_motor_max <= 16'd1000;
            r_start_thr <= 16'd50;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ROLL_KP:   r_roll_kp   <= i_cfg_data;
                REG_ROLL_KD:   r_roll_kd   <= i_cfg_data;
                REG_PITCH_KP:  r_pitch_kp  <= i_cfg_data;
                REG_PITCH_KD:  r_pitch_kd  <= i_cfg_data;
                REG_YAW_KP:    r_yaw_kp    <= i_cfg_data;
                REG_YAW_KD:    r_yaw_kd    <= i_cfg_data;
                REG_MOTOR_MAX: r_motor_max <= i_cfg_data;
                REG_START_THR: r_start_thr <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Pipeline valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Input payload register.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // Controller state and result register; both advance with the item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd        <= 1'b0;
            r_bwd        <= 1'b0;
            r_left       <= 1'b0;
            r_right      <= 1'b0;
            r_yaw_code   <= YAW_ZERO;
            r_thr        <= '0;
            r_prev_roll  <= '0;
            r_prev_pitch <= '0;
            r_prev_yaw   <= '0;
            r_out        <= '0;
        end else if (w_adv) begin
            r_fwd      <= n_fwd;
            r_bwd      <= n_bwd;
            r_left     <= n_left;
            r_right    <= n_right;
            r_yaw_code <= n_yaw_code;
            r_thr      <= n_thr;
            r_out      <= n_out;
            if (w_tick) begin
                r_prev_roll  <= r_in.roll_meas;
                r_prev_pitch <= r_in.pitch_meas;
                r_prev_yaw   <= r_in.yaw_meas;
            end
        end
    end

    // Terms for the assertions below.
    logic w_low_tick, w_out_zero, w_flip, w_fault;
    assign w_low_tick = w_adv && w_tick && (r_thr <= r_start_thr);
    assign w_out_zero = (r_out.motor_one == '0) && (r_out.motor_two == '0) &&
                        (r_out.motor_three == '0) && (r_out.motor_four == '0);
    assign w_flip     = w_adv && w_unknown;
    assign w_fault    = r_out.fault_toggle;

    // A tick at or below the start threshold leaves every motor at zero.
    `ASSERT_CLK(a_low_thr_zero, i_clk, i_rst_n, w_low_tick |=> w_out_zero)
    // An unknown command flips the fault level seen in the next result.
    `ASSERT_CLK(a_fault_flip, i_clk, i_rst_n, w_flip |=> (w_fault != $past(w_fault)))
    // With the result register empty the input side is never stalled.
    `ASSERT_CLK(a_ready_free, i_clk, i_rst_n, !r_out_valid |-> o_in_ready)

endmodule
